// ----- rtl/core/fss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg: shared types and constants
// Widths, codes, queue entry layout and controller/datapath interface.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int USER_COUNT  = 5;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int ID_W        = 10;
  localparam int OWN_W       = 3;
  localparam int PRI_W       = 8;
  localparam int TOT_W       = 31;
  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
  localparam logic [OWN_W-1:0] USER_LAST = OWN_W'(USER_COUNT - 1);
  localparam logic [IDX_W-1:0] DEPTH_CNT = IDX_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_SCHEDULE = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_SCHEDULED = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_ACCEPTED  = 2'd2,
    STS_REFUSED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_IN   = 2'd0,
    SEL_CUR  = 2'd1,
    SEL_ZERO = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [OWN_W-1:0] owner;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_FIND_RD, S_FIND_CHK, S_SHIFT_RD, S_SHIFT_WR, S_PICK,
    S_PRES_RD, S_PRES_CHK, S_MIN, S_FIRST_RD, S_FIRST_CHK, S_RESP
  } state_t;

  typedef struct packed {
    logic     latch_in;
    logic     idx_clr;
    logic     idx_inc;
    logic     uidx_clr;
    logic     uidx_inc;
    logic     rd_next;
    logic     save_hit;
    logic     wr_ins;
    logic     wr_shift;
    logic     len_dec;
    logic     append;
    logic     clr_cur;
    logic     slice_dec;
    logic     pres_clr;
    logic     pres_upd;
    logic     min_upd;
    logic     set_cur;
    logic     res_set;
    status_t  res_status;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    in_bad;
    logic    give_up;
    logic    cur_valid;
    logic    slices_zero;
    logic    at_end;
    logic    hit;
    logic    shift_end;
    logic    len_zero;
    logic    user_end;
    logic    owner_match;
    logic    out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/fss_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_ctrl: scheduler sequencer
// Steps the datapath through queue scans, shifts, user pick and response.
// ----------------------------------------------------------------------------
module fss_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  fss_pkg::sts_t   sts,
  output fss_pkg::cmd_t   cmd
);

  fss_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fss_pkg::S_IDLE: begin
        if (in_valid) state_next = fss_pkg::S_DECIDE;
      end
      fss_pkg::S_DECIDE: begin
        case (sts.action)
          fss_pkg::ACT_INSERT:   state_next = sts.in_bad ? fss_pkg::S_RESP : fss_pkg::S_FIND_RD;
          fss_pkg::ACT_REMOVE:   state_next = fss_pkg::S_FIND_RD;
          fss_pkg::ACT_SCHEDULE: state_next = sts.cur_valid ? fss_pkg::S_FIND_RD : fss_pkg::S_PICK;
          default:               state_next = fss_pkg::S_RESP;
        endcase
      end
      fss_pkg::S_FIND_RD: begin
        if (!sts.at_end) begin
          state_next = fss_pkg::S_FIND_CHK;
        end else if (sts.action == fss_pkg::ACT_SCHEDULE) begin
          state_next = fss_pkg::S_PICK;
        end else begin
          state_next = fss_pkg::S_RESP;
        end
      end
      fss_pkg::S_FIND_CHK: begin
        if (!sts.hit) begin
          state_next = fss_pkg::S_FIND_RD;
        end else if (sts.action == fss_pkg::ACT_REMOVE) begin
          state_next = fss_pkg::S_SHIFT_RD;
        end else if (sts.action == fss_pkg::ACT_SCHEDULE &&
                     (sts.give_up || sts.slices_zero)) begin
          state_next = fss_pkg::S_SHIFT_RD;
        end else begin
          state_next = fss_pkg::S_RESP;
        end
      end
      fss_pkg::S_SHIFT_RD: begin
        if (!sts.shift_end) begin
          state_next = fss_pkg::S_SHIFT_WR;
        end else if (sts.action == fss_pkg::ACT_SCHEDULE) begin
          state_next = fss_pkg::S_PICK;
        end else begin
          state_next = fss_pkg::S_RESP;
        end
      end
      fss_pkg::S_SHIFT_WR:  state_next = fss_pkg::S_SHIFT_RD;
      fss_pkg::S_PICK:      state_next = sts.len_zero ? fss_pkg::S_RESP : fss_pkg::S_PRES_RD;
      fss_pkg::S_PRES_RD:   state_next = sts.at_end ? fss_pkg::S_MIN : fss_pkg::S_PRES_CHK;
      fss_pkg::S_PRES_CHK:  state_next = fss_pkg::S_PRES_RD;
      fss_pkg::S_MIN:       state_next = sts.user_end ? fss_pkg::S_FIRST_RD : fss_pkg::S_MIN;
      fss_pkg::S_FIRST_RD:  state_next = fss_pkg::S_FIRST_CHK;
      fss_pkg::S_FIRST_CHK: state_next = sts.owner_match ? fss_pkg::S_RESP : fss_pkg::S_FIRST_RD;
      fss_pkg::S_RESP: begin
        if (sts.out_free) state_next = fss_pkg::S_IDLE;
      end
      default: state_next = fss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      fss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.latch_in = in_valid;
        cmd.idx_clr = 1'b1;
      end
      fss_pkg::S_DECIDE: begin
        if ((sts.action == fss_pkg::ACT_INSERT && sts.in_bad) ||
            sts.action == fss_pkg::ACT_NONE) begin
          cmd.res_set = 1'b1;
          cmd.res_status = fss_pkg::STS_REFUSED;
          cmd.res_sel = fss_pkg::SEL_IN;
        end
      end
      fss_pkg::S_FIND_RD: begin
        if (sts.at_end) begin
          if (sts.action == fss_pkg::ACT_INSERT) begin
            cmd.wr_ins = 1'b1;
            cmd.res_set = 1'b1;
            cmd.res_status = fss_pkg::STS_ACCEPTED;
            cmd.res_sel = fss_pkg::SEL_IN;
          end else if (sts.action == fss_pkg::ACT_REMOVE) begin
            cmd.res_set = 1'b1;
            cmd.res_status = fss_pkg::STS_REFUSED;
            cmd.res_sel = fss_pkg::SEL_IN;
          end
        end
      end
      fss_pkg::S_FIND_CHK: begin
        if (!sts.hit) begin
          cmd.idx_inc = 1'b1;
        end else if (sts.action == fss_pkg::ACT_INSERT) begin
          cmd.res_set = 1'b1;
          cmd.res_status = fss_pkg::STS_REFUSED;
          cmd.res_sel = fss_pkg::SEL_IN;
        end else if (sts.action == fss_pkg::ACT_SCHEDULE) begin
          if (!sts.give_up && !sts.slices_zero) begin
            cmd.slice_dec = 1'b1;
            cmd.res_set = 1'b1;
            cmd.res_status = fss_pkg::STS_SCHEDULED;
            cmd.res_sel = fss_pkg::SEL_CUR;
          end else begin
            cmd.save_hit = 1'b1;
          end
        end
      end
      fss_pkg::S_SHIFT_RD: begin
        if (!sts.shift_end) begin
          cmd.rd_next = 1'b1;
        end else if (sts.action == fss_pkg::ACT_SCHEDULE) begin
          cmd.append = 1'b1;
        end else begin
          cmd.len_dec = 1'b1;
          cmd.clr_cur = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_status = fss_pkg::STS_ACCEPTED;
          cmd.res_sel = fss_pkg::SEL_IN;
        end
      end
      fss_pkg::S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      fss_pkg::S_PICK: begin
        cmd.idx_clr = 1'b1;
        cmd.uidx_clr = 1'b1;
        cmd.pres_clr = 1'b1;
        if (sts.len_zero) begin
          cmd.res_set = 1'b1;
          cmd.res_status = fss_pkg::STS_EMPTY;
          cmd.res_sel = fss_pkg::SEL_ZERO;
        end
      end
      fss_pkg::S_PRES_CHK: begin
        cmd.pres_upd = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      fss_pkg::S_MIN: begin
        cmd.min_upd = 1'b1;
        cmd.uidx_inc = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      fss_pkg::S_FIRST_CHK: begin
        if (sts.owner_match) begin
          cmd.set_cur = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_status = fss_pkg::STS_SCHEDULED;
          cmd.res_sel = fss_pkg::SEL_CUR;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      fss_pkg::S_RESP: begin
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/fss_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_dp: scheduler datapath
// Run queue memory, current task, user totals, pick registers, result register.
// ----------------------------------------------------------------------------
module fss_dp (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  [23:0]                in_data,
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic [15:0]                out_data,
  input  fss_pkg::cmd_t              cmd,
  output fss_pkg::sts_t              sts
);

  fss_pkg::entry_t                 mem [fss_pkg::QUEUE_DEPTH];
  fss_pkg::entry_t                 rd_data;
  fss_pkg::entry_t                 saved;
  logic [fss_pkg::TOT_W-1:0]       totals [fss_pkg::USER_COUNT];
  logic [fss_pkg::USER_COUNT-1:0]  present;
  logic [fss_pkg::IDX_W-1:0]       len;
  logic [fss_pkg::IDX_W-1:0]       idx;
  logic [fss_pkg::IDX_W-1:0]       idx_plus;
  logic [fss_pkg::OWN_W-1:0]       uidx;
  logic [fss_pkg::OWN_W-1:0]       best_user;
  logic [fss_pkg::TOT_W-1:0]       best_tot;
  logic                            best_found;
  logic [fss_pkg::ID_W-1:0]        cur_slot;
  logic                            cur_valid;
  logic [fss_pkg::PRI_W-1:0]       slices_left;
  fss_pkg::action_t                in_action;
  logic [fss_pkg::ID_W-1:0]        in_id;
  logic [fss_pkg::OWN_W-1:0]       in_owner;
  logic [fss_pkg::PRI_W-1:0]       in_pri;
  logic                            in_give;
  fss_pkg::status_t                res_status;
  fss_pkg::res_sel_t               res_sel;
  logic [fss_pkg::ADDR_W-1:0]      rd_addr;
  logic [fss_pkg::ID_W-1:0]        key;
  logic [fss_pkg::ID_W-1:0]        res_id;
  logic [fss_pkg::TOT_W:0]         sum;
  logic [fss_pkg::TOT_W-1:0]       uid_tot;

  assign idx_plus = idx + 1'b1;
  assign rd_addr  = cmd.rd_next ? idx_plus[fss_pkg::ADDR_W-1:0] : idx[fss_pkg::ADDR_W-1:0];
  assign key      = (in_action == fss_pkg::ACT_SCHEDULE) ? cur_slot : in_id;
  assign sum      = {1'b0, totals[saved.owner]} + {{(fss_pkg::TOT_W-fss_pkg::PRI_W+1){1'b0}}, saved.pri};
  assign uid_tot  = totals[uidx];

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.wr_ins) begin
      mem[len[fss_pkg::ADDR_W-1:0]] <= '{pri: in_pri, owner: in_owner, id: in_id};
    end else if (cmd.wr_shift) begin
      mem[idx[fss_pkg::ADDR_W-1:0]] <= rd_data;
    end else if (cmd.append) begin
      mem[fss_pkg::ADDR_W'(len - 1'b1)] <= saved;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_action <= fss_pkg::action_t'(in_data[1:0]);
      in_id     <= in_data[11:2];
      in_owner  <= in_data[14:12];
      in_pri    <= in_data[22:15];
      in_give   <= in_data[23];
    end
    if (cmd.save_hit) saved <= rd_data;
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_sel    <= cmd.res_sel;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_plus;
    end
    if (cmd.uidx_clr) begin
      uidx <= '0;
    end else if (cmd.uidx_inc) begin
      uidx <= uidx + 1'b1;
    end
    if (cmd.pres_clr) begin
      present    <= '0;
      best_found <= 1'b0;
      best_user  <= '0;
      best_tot   <= '0;
    end else begin
      if (cmd.pres_upd) present[rd_data.owner] <= 1'b1;
      if (cmd.min_upd && present[uidx] && (!best_found || uid_tot < best_tot)) begin
        best_found <= 1'b1;
        best_user  <= uidx;
        best_tot   <= uid_tot;
      end
    end
    if (cmd.out_load) begin
      out_data <= {4'b0, res_status, res_id};
    end
  end

  always_comb begin
    case (res_sel)
      fss_pkg::SEL_IN:  res_id = in_id;
      fss_pkg::SEL_CUR: res_id = cur_slot;
      default:          res_id = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len         <= '0;
      cur_slot    <= '0;
      cur_valid   <= 1'b0;
      slices_left <= '0;
      out_valid   <= 1'b0;
      for (int u = 0; u < fss_pkg::USER_COUNT; u++) totals[u] <= '0;
    end else begin
      if (cmd.wr_ins) len <= len + 1'b1;
      if (cmd.len_dec) len <= len - 1'b1;
      if (cmd.clr_cur && cur_valid && cur_slot == in_id) cur_valid <= 1'b0;
      if (cmd.slice_dec) slices_left <= slices_left - 1'b1;
      if (cmd.append && saved.owner <= fss_pkg::USER_LAST) begin
        totals[saved.owner] <= sum[fss_pkg::TOT_W] ? fss_pkg::TOTAL_MAX : sum[fss_pkg::TOT_W-1:0];
      end
      if (cmd.set_cur) begin
        cur_slot    <= rd_data.id;
        cur_valid   <= 1'b1;
        slices_left <= rd_data.pri - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.action      = in_action;
    sts.in_bad      = (in_pri == '0) || (in_owner > fss_pkg::USER_LAST) ||
                      (len >= fss_pkg::DEPTH_CNT);
    sts.give_up     = in_give;
    sts.cur_valid   = cur_valid;
    sts.slices_zero = (slices_left == '0);
    sts.at_end      = (idx >= len);
    sts.hit         = (rd_data.id == key);
    sts.shift_end   = (idx_plus >= len);
    sts.len_zero    = (len == '0);
    sts.user_end    = (uidx == fss_pkg::USER_LAST);
    sts.owner_match = (rd_data.owner == best_user);
    sts.out_free    = !out_valid || out_ready;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= fss_pkg::DEPTH_CNT) else $error("queue length over depth");
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_ins |-> len < fss_pkg::DEPTH_CNT) else $error("insert into full queue");
  a_cur_set: assert property (@(posedge clk) disable iff (rst)
    cmd.set_cur |=> cur_valid && best_found) else $error("pick without candidate");

endmodule
`default_nettype wire

// ----- rtl/core/fair_share_slice_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fair_share_slice_scheduler: fair-share round-robin slice scheduler
// Run queue with per-user used-time totals; picks least-charged user's task.
// ----------------------------------------------------------------------------
// One item at a time: a reschedule walks the queue serially, and the next input
//   can be taken in the cycle after the result loads; a stalled result holds the
//   block until it is taken.
// Reset clears length, current task and all totals at once; no clearing pass.
// ----------------------------------------------------------------------------
module fair_share_slice_scheduler (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,  // action, task_id, owner, priority_req, give_up
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata   // chosen_id, status, zero pad
);

  fss_pkg::cmd_t cmd;
  fss_pkg::sts_t sts;

  fss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// ----- tb/tb_fair_share_slice_scheduler.sv -----
// ----------------------------------------------------------------------------
// tb_fair_share_slice_scheduler: stream-level test of the slice scheduler
// Drives directed and random-burst insert, remove, schedule and no-action transfers,
// predicts the run queue, current task, slice count and per-user totals, and checks
// every result transfer in order against the prediction.
// ----------------------------------------------------------------------------
module tb_fair_share_slice_scheduler;

  localparam int ID_W        = fss_pkg::ID_W;
  localparam int OWN_W       = fss_pkg::OWN_W;
  localparam int PRI_W       = fss_pkg::PRI_W;
  localparam int TOT_W       = fss_pkg::TOT_W;
  localparam int USER_COUNT  = fss_pkg::USER_COUNT;
  localparam int QUEUE_DEPTH = fss_pkg::QUEUE_DEPTH;

  class sched_board;
    logic [ID_W-1:0]  q_id[$];
    logic [OWN_W-1:0] q_own[$];
    logic [PRI_W-1:0] q_pri[$];
    logic [ID_W-1:0]  cur_id;
    bit               cur_ok;
    logic [PRI_W-1:0] slices;
    logic [TOT_W-1:0] used[USER_COUNT];
    logic [ID_W-1:0]  want_id[$];
    fss_pkg::status_t want_sts[$];
    int               errors;

    function new();
      cur_ok = 0;
      cur_id = '0;
      slices = '0;
      errors = 0;
      foreach (used[i]) used[i] = '0;
    endfunction

    function int find_task(logic [ID_W-1:0] id);
      foreach (q_id[i]) if (q_id[i] == id) return i;
      return -1;
    endfunction

    function void push(logic [ID_W-1:0] id, fss_pkg::status_t s);
      want_id.push_back(id);
      want_sts.push_back(s);
    endfunction

    function void note(fss_pkg::action_t act, logic [ID_W-1:0] id, logic [OWN_W-1:0] own,
                       logic [PRI_W-1:0] pri, bit give);
      int pos, usr;
      bit seen[USER_COUNT];
      bit got;
      logic [ID_W-1:0] cid;
      logic [OWN_W-1:0] cown;
      logic [PRI_W-1:0] cpri;
      logic [TOT_W:0] sum;
      got = 0;
      usr = 0;
      case (act)
        fss_pkg::ACT_INSERT: begin
          if (pri == 0 || own >= USER_COUNT || q_id.size() >= QUEUE_DEPTH ||
              find_task(id) >= 0) push(id, fss_pkg::STS_REFUSED);
          else begin
            q_id.push_back(id); q_own.push_back(own); q_pri.push_back(pri);
            push(id, fss_pkg::STS_ACCEPTED);
          end
        end
        fss_pkg::ACT_REMOVE: begin
          pos = find_task(id);
          if (pos < 0) push(id, fss_pkg::STS_REFUSED);
          else begin
            q_id.delete(pos); q_own.delete(pos); q_pri.delete(pos);
            if (cur_ok && cur_id == id) cur_ok = 0;
            push(id, fss_pkg::STS_ACCEPTED);
          end
        end
        fss_pkg::ACT_SCHEDULE: begin
          pos = cur_ok ? find_task(cur_id) : -1;
          if (pos >= 0 && !give && slices != 0) begin
            slices--;
            push(cur_id, fss_pkg::STS_SCHEDULED);
            return;
          end
          if (pos >= 0) begin
            cid = q_id[pos]; cown = q_own[pos]; cpri = q_pri[pos];
            q_id.delete(pos); q_own.delete(pos); q_pri.delete(pos);
            q_id.push_back(cid); q_own.push_back(cown); q_pri.push_back(cpri);
            sum = {1'b0, used[cown]} + cpri;
            used[cown] = sum > fss_pkg::TOTAL_MAX ? fss_pkg::TOTAL_MAX : sum[TOT_W-1:0];
          end
          if (q_id.size() == 0) begin
            push('0, fss_pkg::STS_EMPTY);
            return;
          end
          foreach (seen[i]) seen[i] = 0;
          foreach (q_own[i]) seen[q_own[i]] = 1;
          for (int u = 0; u < USER_COUNT; u++)
            if (seen[u] && (!got || used[u] < used[usr])) begin
              usr = u; got = 1;
            end
          pos = 0;
          for (int i = q_own.size() - 1; i >= 0; i--) if (q_own[i] == usr) pos = i;
          cur_id = q_id[pos];
          cur_ok = 1;
          slices = q_pri[pos] - 1'b1;
          push(cur_id, fss_pkg::STS_SCHEDULED);
        end
        default: push(id, fss_pkg::STS_REFUSED);
      endcase
    endfunction

    function void check(logic [15:0] data);
      logic [ID_W-1:0] eid;
      fss_pkg::status_t es;
      if (want_id.size() == 0) begin
        $error("result with no expectation: %h", data);
        errors++;
        return;
      end
      eid = want_id.pop_front();
      es = want_sts.pop_front();
      if (data[9:0] !== eid) begin
        $error("chosen_id: expected %0d, got %0d", eid, data[9:0]);
        errors++;
      end
      if (data[11:10] !== es) begin
        $error("status: expected %0d, got %0d", es, data[11:10]);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;
  sched_board  board;
  bit          hold_off;
  bit          stim_done;
  int          idle_cycles;

  fair_share_slice_scheduler dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // tdata: action, task_id, owner, priority_req, give_up
  task automatic send(fss_pkg::action_t act, logic [ID_W-1:0] id, logic [OWN_W-1:0] own,
                      logic [PRI_W-1:0] pri, bit give);
    s_axis_tdata  <= {give, pri, own, id, act};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    board.note(act, id, own, pri, give);
    @(negedge clk);
  endtask

  task automatic gap();
    if ($urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int n;
    n = board.q_id.size();
    if (n > 0 && $urandom_range(3) != 0) return board.q_id[$urandom_range(n - 1)];
    return $urandom_range(1, 0) ? ID_W'($urandom_range(23)) : ID_W'($urandom);
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 40)
      send(fss_pkg::ACT_INSERT, pick_id(),
           $urandom_range(19) == 0 ? OWN_W'($urandom_range(7)) : OWN_W'($urandom_range(4)),
           $urandom_range(19) == 0 ? PRI_W'($urandom) : PRI_W'($urandom_range(6, 1)),
           1'($urandom_range(1)));
    else if (r < 60)
      send(fss_pkg::ACT_REMOVE, pick_id(), OWN_W'($urandom), PRI_W'($urandom),
           1'($urandom_range(1)));
    else if (r < 97)
      send(fss_pkg::ACT_SCHEDULE, ID_W'($urandom), OWN_W'($urandom), PRI_W'($urandom),
           $urandom_range(3) == 0);
    else
      send(fss_pkg::ACT_NONE, ID_W'($urandom), OWN_W'($urandom), PRI_W'($urandom),
           1'($urandom_range(1)));
  endtask

  // receiver stall pattern plus one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    hold_off = 0;
    @(negedge clk);
    while (!rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (($time / 640) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= $urandom_range(3) != 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || hold_off || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    idle_cycles = 0;
    stim_done = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(fss_pkg::ACT_SCHEDULE, 10'd5, 3'd0, 8'd1, 1'b0);
    send(fss_pkg::ACT_REMOVE, 10'd1023, 3'd0, 8'd1, 1'b0);
    send(fss_pkg::ACT_INSERT, 10'd0, 3'd0, 8'd0, 1'b0);
    send(fss_pkg::ACT_INSERT, 10'd1, 3'd5, 8'd3, 1'b0);
    send(fss_pkg::ACT_INSERT, 10'd2, 3'd7, 8'd3, 1'b0);
    send(fss_pkg::ACT_INSERT, 10'd1023, 3'd4, 8'd255, 1'b1);
    send(fss_pkg::ACT_INSERT, 10'd1023, 3'd1, 8'd2, 1'b0);
    send(fss_pkg::ACT_INSERT, 10'd0, 3'd0, 8'd2, 1'b0);
    send(fss_pkg::ACT_INSERT, 10'd7, 3'd0, 8'd1, 1'b0);
    send(fss_pkg::ACT_SCHEDULE, 10'd0, 3'd0, 8'd0, 1'b0);
    send(fss_pkg::ACT_SCHEDULE, 10'd0, 3'd0, 8'd0, 1'b0);
    send(fss_pkg::ACT_SCHEDULE, 10'd0, 3'd0, 8'd0, 1'b1);
    send(fss_pkg::ACT_SCHEDULE, 10'd0, 3'd0, 8'd0, 1'b0);
    send(fss_pkg::ACT_REMOVE, board.cur_id, 3'd0, 8'd0, 1'b0);
    send(fss_pkg::ACT_SCHEDULE, 10'd0, 3'd0, 8'd0, 1'b0);
    send(fss_pkg::ACT_NONE, 10'd512, 3'd7, 8'd255, 1'b1);
    for (int i = 0; i < 16; i++)
      send(fss_pkg::ACT_INSERT, ID_W'(100 + i), OWN_W'(i % 5), 8'd1, 1'b0);
    send(fss_pkg::ACT_SCHEDULE, 10'd0, 3'd0, 8'd0, 1'b1);

    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (12) send(fss_pkg::ACT_SCHEDULE, 10'd0, 3'd0, 8'd0, 1'($urandom_range(1)));
    join

    for (int n = 0; n < 1900; ) begin
      int burst;
      burst = $urandom_range(30, 1);
      repeat (burst) begin
        random_item();
        n++;
      end
      gap();
      if ($urandom_range(60) == 0)
        while (board.q_id.size() > 0)
          send(fss_pkg::ACT_REMOVE, board.q_id[0], OWN_W'($urandom), PRI_W'($urandom),
               1'($urandom_range(1)));
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    stim_done = 1;

    while (board.want_id.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (board.errors == 0 && board.want_id.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/fss_pkg.sv
rtl/core/fss_ctrl.sv
rtl/core/fss_dp.sv
rtl/core/fair_share_slice_scheduler.sv
tb/tb_fair_share_slice_scheduler.sv
